// ----- design/i2c_register_read_sequencer_core_assert.svh -----
// Assertion macros for the I2C register-read sequencer.
`ifndef I2C_REGISTER_READ_SEQUENCER_CORE_ASSERT_SVH
`define I2C_REGISTER_READ_SEQUENCER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define I2CRS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("i2crs assertion failed");

// Next-cycle implication, sampled on clk_i, off during reset.
`define I2CRS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("i2crs assertion failed");

`endif

// ----- design/i2crs_pkg.sv -----
// Types and constants shared by the I2C register-read sequencer.
package i2crs_pkg;

  localparam int unsigned ByteBits = 8;

  localparam logic KindPoll  = 1'b0;
  localparam logic KindStart = 1'b1;

  typedef enum logic [9:0] {
    PH_IDLE    = 10'b00_0000_0001,
    PH_W_START = 10'b00_0000_0010,
    PH_W_ADDR  = 10'b00_0000_0100,
    PH_W_DATA  = 10'b00_0000_1000,
    PH_W_STOP  = 10'b00_0001_0000,
    PH_R_START = 10'b00_0010_0000,
    PH_R_ADDR  = 10'b00_0100_0000,
    PH_R_BYTE1 = 10'b00_1000_0000,
    PH_R_BYTE2 = 10'b01_0000_0000,
    PH_R_STOP  = 10'b10_0000_0000
  } phase_e;

  typedef enum logic [1:0] {
    ACK_KEEP    = 2'd0,
    ACK_ENABLE  = 2'd1,
    ACK_DISABLE = 2'd2
  } ack_ctrl_e;

  typedef struct packed {
    logic                start_seen;
    logic                address_acked;
    logic                ack_failed;
    logic                byte_sent;
    logic                byte_received;
    logic                bus_busy;
    logic [ByteBits-1:0] received_byte;
  } status_t;

  typedef struct packed {
    logic                kind;
    logic [6:0]          target_address;
    logic [ByteBits-1:0] register_pointer;
    status_t             status;
  } item_t;

  typedef struct packed {
    logic                  issue_start;
    logic                  send_address;
    logic [ByteBits-1:0]   address_byte;
    logic                  send_data;
    logic [ByteBits-1:0]   data_byte;
    logic                  issue_stop;
    ack_ctrl_e             ack_control;
    logic                  clear_ack_failure;
    logic                  done_res;
    logic                  error;
    logic [2*ByteBits-1:0] read_value;
    logic                  in_progress;
  } result_t;

endpackage

// ----- design/i2crs_fsm.sv -----
// Sequencer state and command decode for one transaction per cycle while step_i is high.
module i2crs_fsm (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  i2crs_pkg::item_t  item_i,
  output i2crs_pkg::result_t result_o
);

  i2crs_pkg::phase_e phase_q, phase_d;
  logic [6:0]                      addr_q, addr_d;
  logic [i2crs_pkg::ByteBits-1:0]  ptr_q, ptr_d;
  logic [2*i2crs_pkg::ByteBits-1:0] value_q, value_d;
  logic                            err_q, err_d;
  i2crs_pkg::status_t              st;

  assign st = item_i.status;

  always_comb begin
    phase_d  = phase_q;
    addr_d   = addr_q;
    ptr_d    = ptr_q;
    value_d  = value_q;
    err_d    = err_q;
    result_o = '0;
    result_o.ack_control = i2crs_pkg::ACK_KEEP;
    if (item_i.kind == i2crs_pkg::KindStart) begin
      addr_d  = item_i.target_address;
      ptr_d   = item_i.register_pointer;
      err_d   = 1'b0;
      phase_d = i2crs_pkg::PH_W_START;
      result_o.issue_start = 1'b1;
    end else begin
      unique case (phase_q)
        i2crs_pkg::PH_W_START: begin
          if (st.start_seen) begin
            result_o.send_address = 1'b1;
            result_o.address_byte = {addr_q, 1'b0};
            phase_d = i2crs_pkg::PH_W_ADDR;
          end
        end
        i2crs_pkg::PH_W_ADDR: begin
          if (st.address_acked) begin
            result_o.send_data = 1'b1;
            result_o.data_byte = ptr_q;
            phase_d = i2crs_pkg::PH_W_DATA;
          end else if (st.ack_failed) begin
            result_o.clear_ack_failure = 1'b1;
            err_d   = 1'b1;
            phase_d = i2crs_pkg::PH_IDLE;
          end
        end
        i2crs_pkg::PH_W_DATA: begin
          if (st.byte_sent) begin
            result_o.issue_stop = 1'b1;
            phase_d = i2crs_pkg::PH_W_STOP;
          end else if (st.ack_failed) begin
            result_o.clear_ack_failure = 1'b1;
            err_d   = 1'b1;
            phase_d = i2crs_pkg::PH_IDLE;
          end
        end
        i2crs_pkg::PH_W_STOP: begin
          if (!st.bus_busy) begin
            result_o.issue_start = 1'b1;
            phase_d = i2crs_pkg::PH_R_START;
          end
        end
        i2crs_pkg::PH_R_START: begin
          if (st.start_seen) begin
            result_o.send_address = 1'b1;
            result_o.address_byte = {addr_q, 1'b1};
            result_o.ack_control  = i2crs_pkg::ACK_ENABLE;
            phase_d = i2crs_pkg::PH_R_ADDR;
          end
        end
        i2crs_pkg::PH_R_ADDR: begin
          if (st.address_acked) begin
            phase_d = i2crs_pkg::PH_R_BYTE1;
          end else if (st.ack_failed) begin
            result_o.clear_ack_failure = 1'b1;
            err_d   = 1'b1;
            phase_d = i2crs_pkg::PH_IDLE;
          end
        end
        i2crs_pkg::PH_R_BYTE1: begin
          if (st.byte_received) begin
            value_d = {{i2crs_pkg::ByteBits{1'b0}}, st.received_byte};
            result_o.ack_control = i2crs_pkg::ACK_DISABLE;
            result_o.issue_stop  = 1'b1;
            phase_d = i2crs_pkg::PH_R_BYTE2;
          end
        end
        i2crs_pkg::PH_R_BYTE2: begin
          if (st.byte_received) begin
            value_d = {value_q[i2crs_pkg::ByteBits-1:0], st.received_byte};
            phase_d = i2crs_pkg::PH_R_STOP;
          end
        end
        i2crs_pkg::PH_R_STOP: begin
          if (!st.bus_busy) begin
            result_o.done_res = 1'b1;
            phase_d = i2crs_pkg::PH_IDLE;
          end
        end
        default: begin
          phase_d = i2crs_pkg::PH_IDLE;
        end
      endcase
    end
    result_o.error       = err_d;
    result_o.read_value  = value_d;
    result_o.in_progress = (phase_d != i2crs_pkg::PH_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= i2crs_pkg::PH_IDLE;
      addr_q  <= '0;
      ptr_q   <= '0;
      value_q <= '0;
      err_q   <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d;
      addr_q  <= addr_d;
      ptr_q   <= ptr_d;
      value_q <= value_d;
      err_q   <= err_d;
    end
  end

endmodule

// ----- design/i2c_register_read_sequencer_core.sv -----
// I2C register-read sequencer: reads one 16-bit device register, one transaction per status poll,
// taking one transaction per clock unless a held result stalls it (out_ready_i low); the input
// register and the result register each hold one transaction, and the phase register updates
// as a transaction moves from the first to the second.
module i2c_register_read_sequencer_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        kind_i,
  input  logic [6:0]  target_address_i,
  input  logic [7:0]  register_pointer_i,
  input  logic        start_seen_i,
  input  logic        address_acked_i,
  input  logic        ack_failed_i,
  input  logic        byte_sent_i,
  input  logic        byte_received_i,
  input  logic        bus_busy_i,
  input  logic [7:0]  received_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        issue_start_o,
  output logic        send_address_o,
  output logic [7:0]  address_byte_o,
  output logic        send_data_o,
  output logic [7:0]  data_byte_o,
  output logic        issue_stop_o,
  output logic [1:0]  ack_control_o,
  output logic        clear_ack_failure_o,
  output logic        done_res_o,
  output logic        error_o,
  output logic [15:0] read_value_o,
  output logic        in_progress_o
);

  `include "i2c_register_read_sequencer_core_assert.svh"

  logic                 in_valid_q, in_valid_d;
  i2crs_pkg::item_t     in_item_q;
  logic                 out_valid_q, out_valid_d;
  i2crs_pkg::result_t   out_res_q, res;
  logic                 advance, step, in_fire;

  assign advance    = !out_valid_q || out_ready_i;
  assign step       = in_valid_q && advance;
  assign in_ready_o = !in_valid_q || advance;
  assign in_fire    = in_valid_i && in_ready_o;

  assign in_valid_d  = in_fire ? 1'b1 : (step ? 1'b0 : in_valid_q);
  assign out_valid_d = step ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_item_q.kind                 <= kind_i;
      in_item_q.target_address       <= target_address_i;
      in_item_q.register_pointer     <= register_pointer_i;
      in_item_q.status.start_seen    <= start_seen_i;
      in_item_q.status.address_acked <= address_acked_i;
      in_item_q.status.ack_failed    <= ack_failed_i;
      in_item_q.status.byte_sent     <= byte_sent_i;
      in_item_q.status.byte_received <= byte_received_i;
      in_item_q.status.bus_busy      <= bus_busy_i;
      in_item_q.status.received_byte <= received_byte_i;
    end
    if (step) begin
      out_res_q <= res;
    end
  end

  i2crs_fsm u_fsm (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (in_item_q),
    .result_o (res)
  );

  assign out_valid_o         = out_valid_q;
  assign issue_start_o       = out_res_q.issue_start;
  assign send_address_o      = out_res_q.send_address;
  assign address_byte_o      = out_res_q.address_byte;
  assign send_data_o         = out_res_q.send_data;
  assign data_byte_o         = out_res_q.data_byte;
  assign issue_stop_o        = out_res_q.issue_stop;
  assign ack_control_o       = out_res_q.ack_control;
  assign clear_ack_failure_o = out_res_q.clear_ack_failure;
  assign done_res_o          = out_res_q.done_res;
  assign error_o             = out_res_q.error;
  assign read_value_o        = out_res_q.read_value;
  assign in_progress_o       = out_res_q.in_progress;

  `I2CRS_ASSERT_NEXT(a_step_gives_result, step, out_valid_q)
  `I2CRS_ASSERT_NEXT(a_start_clears_error, step && (in_item_q.kind == i2crs_pkg::KindStart),
                     out_res_q.issue_start && !out_res_q.error && out_res_q.in_progress)
  `I2CRS_ASSERT_NOW(a_done_ends_read, out_valid_q && out_res_q.done_res,
                    !out_res_q.in_progress)
  `I2CRS_ASSERT_NOW(a_ackfail_sets_error, out_valid_q && out_res_q.clear_ack_failure,
                    out_res_q.error && !out_res_q.in_progress)

endmodule
